FILE: rtl/core/lru_pkg.sv
package lru_pkg;

  // Default sizing
  localparam int NUM_BLOCKS_DEF = 64;
  localparam int CAPACITY_DEF   = 8;

  // Width of a block number word
  localparam int BLK_W = 6;

  // Control broadcast to every cell of the recency chain
  typedef struct packed {
    logic upd;   // an in-range access updates the chain this cycle
    logic miss;  // the access found no matching cell
  } lru_ctl_t;

  // What one cell shows to its neighbors
  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] data;
  } lru_link_t;

endpackage

FILE: rtl/core/lru_cell.sv
module lru_cell
  import lru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lru_ctl_t         ctl,
  input  logic [BLK_W-1:0] blk,
  input  logic             left_valid,
  input  lru_link_t        right,
  input  logic             seen_in,
  output logic             seen_out,
  output logic             match,
  output lru_link_t        link
);

  logic             valid_r, valid_nxt;
  logic [BLK_W-1:0] data_r, data_nxt;
  logic             shift, load;

  // Compare the stored block against the access
  assign match    = valid_r && (data_r == blk);
  // A match here or below moves this cell one step toward the least recent end
  assign seen_out = seen_in | match;
  assign shift    = ctl.upd & seen_out;
  // First free cell takes the new block on a miss with room
  assign load     = ctl.upd & ctl.miss & ~valid_r & left_valid;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (shift) begin
      data_nxt = right.valid ? right.data : blk;
    end else if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = blk;
    end
  end

  // Hold valid under reset, data needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign link.valid = valid_r;
  assign link.data  = data_r;

endmodule

FILE: rtl/core/lru_cache_replacement.sv
// LRU replacement tracker for a fully associative cache.
// Input channel: in_valid / in_stall with in_block_number, one access per word.
// Result channel: out_valid / out_stall with out_hit, out_evict_valid and
// out_evicted_block, exactly one result word per accepted access.
// The output register takes the result as the access is accepted. One access
// per cycle unless a result waits on a stalled receiver; the recency chain
// updates in the accept cycle, so the next access already sees the new order.
// The chain is a row of CAPACITY cells, least recent at cell 0; every cell
// compares its block against the access and shifts from its right neighbor.
// Accesses with a block number at or above NUM_BLOCKS give an all-zero result
// and leave the chain untouched.
// Reset empties the chain (no block resident) and drops any pending result.
// While the receiver stalls a pending result, the result holds and in_stall
// rises, so no further access is taken until the output register is free.
module lru_cache_replacement
  import lru_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [BLK_W-1:0] in_block_number,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_hit,
  output logic             out_evict_valid,
  output logic [BLK_W-1:0] out_evicted_block
);

  lru_ctl_t                ctl;
  lru_link_t [CAPACITY-1:0] links;
  logic [CAPACITY-1:0]     match_vec;
  logic [CAPACITY:0]       seen;
  logic                    accept, in_range, hit, full, miss_full;

  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic             out_evict_valid_r, out_evict_valid_nxt;
  logic [BLK_W-1:0] out_evicted_block_r, out_evicted_block_nxt;

  // Stall input only while a result waits on a stalled receiver
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign in_range = (32'(in_block_number) < NUM_BLOCKS);

  assign hit       = in_range & (|match_vec);
  assign full      = links[CAPACITY-1].valid;
  assign miss_full = in_range & ~hit & full;

  assign ctl.upd  = accept & in_range;
  assign ctl.miss = ~hit;
  // A full miss shifts the whole chain, dropping cell 0
  assign seen[0]  = miss_full;

  // Recency chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lru_link_t right_link;
    logic      left_valid;
    if (i == CAPACITY - 1) begin : g_last
      assign right_link.valid = 1'b0;
      assign right_link.data  = in_block_number;
    end else begin : g_mid
      assign right_link = links[i+1];
    end
    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_rest
      assign left_valid = links[i-1].valid;
    end
    lru_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .blk        (in_block_number),
      .left_valid (left_valid),
      .right      (right_link),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .match      (match_vec[i]),
      .link       (links[i])
    );
  end

  // Load a new result word on accept, drop it once taken
  always_comb begin
    out_valid_nxt         = out_valid_r;
    out_hit_nxt           = out_hit_r;
    out_evict_valid_nxt   = out_evict_valid_r;
    out_evicted_block_nxt = out_evicted_block_r;
    if (accept) begin
      out_valid_nxt         = 1'b1;
      out_hit_nxt           = hit;
      out_evict_valid_nxt   = miss_full;
      out_evicted_block_nxt = miss_full ? links[0].data : '0;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r           <= out_hit_nxt;
    out_evict_valid_r   <= out_evict_valid_nxt;
    out_evicted_block_r <= out_evicted_block_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evict_valid   = out_evict_valid_r;
  assign out_evicted_block = out_evicted_block_r;

endmodule

FILE: rtl/core/lru_checker.sv
module lru_checker
  import lru_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_hit,
  input logic             out_evict_valid,
  input logic [BLK_W-1:0] out_evicted_block
);

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit) &&
      $stable(out_evict_valid) && $stable(out_evicted_block))
    else $error("stalled result word changed");

  // Every accepted access yields a result word next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted access gave no result");

  // Input stalls only behind a waiting result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a pending result");

  // Eviction happens only on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evict_valid |-> !out_hit)
    else $error("eviction reported on a hit");

  // No eviction means a zero block number
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evict_valid |-> out_evicted_block == '0)
    else $error("evicted block nonzero without eviction");

endmodule

bind lru_cache_replacement lru_checker u_lru_checker (.*);

FILE: test/lru_order_checker.sv
module lru_order_checker
  import lru_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int CAPACITY   = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [BLK_W-1:0] in_block_number,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             out_hit,
  input  logic             out_evict_valid,
  input  logic [BLK_W-1:0] out_evicted_block,
  output int               error_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             hit;
    logic             evict_valid;
    logic [BLK_W-1:0] evicted_block;
  } access_result_t;

  // Mirror of the cache contents: presence bits and least-recent-first order
  logic             resident [NUM_BLOCKS];
  logic [BLK_W-1:0] recency [$];
  access_result_t   expected_results [$];

  // Apply one access to the mirror and work out the result word it gives
  task automatic touch_block(input logic [BLK_W-1:0] blk, output access_result_t res);
    logic [BLK_W-1:0] victim;
    res = '0;
    if (blk < NUM_BLOCKS) begin
      if (resident[blk]) begin
        // Hit: move the block to the most recent end
        res.hit = 1'b1;
        for (int i = 0; i < recency.size(); i++) begin
          if (recency[i] == blk) begin
            recency.delete(i);
            break;
          end
        end
        recency.push_back(blk);
      end else begin
        // Miss: evict the least recent block when full, then append
        if (recency.size() >= CAPACITY) begin
          victim = recency.pop_front();
          resident[victim]  = 1'b0;
          res.evict_valid   = 1'b1;
          res.evicted_block = victim;
        end
        recency.push_back(blk);
        resident[blk] = 1'b1;
      end
    end
  endtask

  // Compare each accepted result word, then record the prediction for each access
  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (!rst_n) begin
      // Empty the mirror and drop any predictions
      foreach (resident[i]) resident[i] = 1'b0;
      recency.delete();
      expected_results.delete();
      error_count   = 0;
      pending_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_hit, out_evict_valid, out_evicted_block};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word hit=%0b evict_valid=%0b evicted_block=%0d",
                   $time, got.hit, got.evict_valid, got.evicted_block);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            error_count++;
          end
          if (got.evict_valid !== want.evict_valid) begin
            $display("%0t: evict_valid expected %0b actual %0b",
                     $time, want.evict_valid, got.evict_valid);
            error_count++;
          end
          if (got.evicted_block !== want.evicted_block) begin
            $display("%0t: evicted_block expected %0d actual %0d",
                     $time, want.evicted_block, got.evicted_block);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        touch_block(in_block_number, want);
        expected_results.push_back(want);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

FILE: test/tb.sv
module tb
  import lru_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1330;
  localparam int HOLD_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 400000;

  // Fill, hit both ends, evict, and touch the extremes of the block number
  localparam logic [BLK_W-1:0] WARMUP [16] = '{
    6'd0, 6'd63, 6'd0, 6'd63, 6'd1, 6'd2, 6'd3, 6'd4,
    6'd5, 6'd6, 6'd0, 6'd7, 6'd63, 6'd63, 6'd42, 6'd21
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [BLK_W-1:0] in_block_number;
  logic             out_valid;
  logic             out_stall;
  logic             out_hit;
  logic             out_evict_valid;
  logic [BLK_W-1:0] out_evicted_block;
  int               error_count;
  int               pending_count;
  int               words_sent  = 0;
  int               cycle_count = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  lru_cache_replacement dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evict_valid   (out_evict_valid),
    .out_evicted_block (out_evicted_block)
  );

  lru_order_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evict_valid   (out_evict_valid),
    .out_evicted_block (out_evicted_block),
    .error_count       (error_count),
    .pending_count     (pending_count)
  );

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one access word and hold it until the block takes it
  task automatic send_access(input logic [BLK_W-1:0] blk, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_block_number <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // Stimulus and verdict
  initial begin
    logic [BLK_W-1:0] hot_set [10];
    logic [BLK_W-1:0] blk;
    bit               calm;
    int               r;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_block_number <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (WARMUP[i]) send_access(WARMUP[i], 1'b0);

    // Draw mostly from a small working set a bit larger than the cache
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 48 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        foreach (hot_set[i]) hot_set[i] = BLK_W'($urandom_range(0, 63));
      end
      r = $urandom_range(0, 99);
      if (r < 70) blk = hot_set[$urandom_range(0, 9)];
      else if (r < 85) blk = hot_set[$urandom_range(0, 5)];
      else blk = BLK_W'($urandom_range(0, 63));
      send_access(blk, calm);
    end
    in_valid <= 1'b0;

    // Drain the remaining result words
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Receiver stalls: runs of free flow, light and heavy stalling, long hold-offs
  initial begin
    bit hold_done;
    int seg;
    int mode;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      // Back up the block once while the sender keeps offering
      if (!hold_done && words_sent >= 400) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      r_mode: begin
        mode = $urandom_range(0, 9);
        seg  = (mode == 9) ? $urandom_range(10, 40) : $urandom_range(8, 80);
      end
      repeat (seg) begin
        if (mode < 4) out_stall <= 1'b0;
        else if (mode < 7) out_stall <= ($urandom_range(0, 3) == 0);
        else if (mode < 9) out_stall <= 1'($urandom_range(0, 1));
        else out_stall <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule

FILE: files.f
rtl/core/lru_pkg.sv
rtl/core/lru_cell.sv
rtl/core/lru_cache_replacement.sv
rtl/core/lru_checker.sv
test/lru_order_checker.sv
test/tb.sv
